[rtl/nwgsp_pkg.sv]
package nwgsp_pkg;

    localparam int MaxLineDefault       = 255;
    localparam int KeptFieldsDefault    = 9;
    localparam int FractionDigitsDefault = 2;

    localparam logic [15:0] WIND_LIMIT_RESET   = 16'd20000;
    localparam logic [15:0] GROUND_LIMIT_RESET = 16'd10000;

    localparam logic [16:0] MS_TO_KN     = 17'd127392;
    localparam logic [16:0] KMH_TO_KN    = 17'd35387;
    localparam logic [15:0] FULL_CIRCLE  = 16'd36000;
    localparam logic [15:0] HALF_CIRCLE  = 16'd18000;

    localparam logic [0:0] CFG_WIND_LIMIT   = 1'd0;
    localparam logic [0:0] CFG_GROUND_LIMIT = 1'd1;

    typedef enum logic [2:0] {
        KIND_REJECT   = 3'd0,
        KIND_APPARENT = 3'd1,
        KIND_TRUE     = 3'd2,
        KIND_GROUND   = 3'd3,
        KIND_HEADING  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        SRC_MWV = 3'd0,
        SRC_VWR = 3'd1,
        SRC_VWT = 3'd2,
        SRC_RMC = 3'd3,
        SRC_VTG = 3'd4,
        SRC_HDT = 3'd5,
        SRC_HDM = 3'd6
    } source_t;

    typedef enum logic [1:0] {
        NUM_LEADING  = 2'd0,
        NUM_INTEGER  = 2'd1,
        NUM_FRACTION = 2'd2,
        NUM_DONE     = 2'd3
    } num_phase_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  source;
        logic [8:0]  wind_angle_deg;
        logic        speed_valid;
        logic [15:0] speed_centiknots;
        logic [15:0] course_centideg;
        logic [15:0] heading_centideg;
        logic [3:0]  seen_flags;
    } out_item_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic logic [15:0] sat16(input logic [19:0] v);
        return (v > 20'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    // hex digit value, bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= "0" && c <= "9") r = {1'b0, c[3:0]};
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            r = {1'b0, c[3:0] + 4'd9};
        return r;
    endfunction

endpackage

[rtl/nmea_wind_gps_sentence_parser.sv]
// nmea 0183 line parser for wind, ground track and heading sentences. characters
// arrive one per request with the last one flagged by end_of_line; one request is
// taken every cycle, and the input stalls only while a flagged character sits in the
// input register and the output register holds a result under stall. per-line
// state (checksum, header letters, per-field value in hundredths) is updated from
// the input register in a single pass; on the flagged character the sentence is
// decoded and one result request is loaded into the output register.
// configuration writes are meant for idle periods only.
module nmea_wind_gps_sentence_parser #(
    parameter int MAX_LINE        = nwgsp_pkg::MaxLineDefault,
    parameter int KEPT_FIELDS     = nwgsp_pkg::KeptFieldsDefault,
    parameter int FRACTION_DIGITS = nwgsp_pkg::FractionDigitsDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  nwgsp_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output nwgsp_pkg::out_item_t out_data,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_wdata
);
    import nwgsp_pkg::*;

    localparam int LenW = $clog2(MAX_LINE + 1);

    // input register
    logic       in_full_reg;
    in_item_t   in_item_reg;
    // output register
    logic       out_full_reg;
    out_item_t  out_item_reg;

    logic [15:0] wind_limit_reg;
    logic [15:0] ground_limit_reg;

    // line state
    logic [LenW-1:0] len_reg,  len_next;
    logic        stopped_reg, stopped_next;
    logic        dollar_reg,  dollar_next;
    logic [5:0][7:0] hdr_reg, hdr_next;
    logic [2:0]  hfill_reg, hfill_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  xstar_reg, xstar_next;
    logic        star_reg, star_next;
    logic [7:0]  rcs_reg, rcs_next;
    logic [1:0]  hexcnt_reg, hexcnt_next;
    logic        hexstop_reg, hexstop_next;
    logic [3:0]  fidx_reg, fidx_next;
    logic        lcomma_reg, lcomma_next;
    logic [KEPT_FIELDS-1:0][15:0] fval_reg, fval_next;
    logic [KEPT_FIELDS-1:0]       fneg_reg, fneg_next;
    logic [KEPT_FIELDS-1:0][7:0]  ffirst_reg, ffirst_next;
    logic [1:0]  frac_reg, frac_next;
    num_phase_t  phase_reg, phase_next;
    logic [3:0]  seen_reg;

    logic        step;
    logic        emit;
    logic [7:0]  c;
    logic [4:0]  hv;
    logic [3:0]  d;
    logic        digit;
    logic [15:0] cur;
    logic [4:0]  field_count;
    logic        checksum_ok;
    out_item_t   eval_result;
    logic [3:0]  eval_seen;

    assign step     = in_full_reg;
    assign emit     = step && in_item_reg.end_of_line;
    // input stage moves when it is empty or its item can retire this cycle
    assign in_stall = in_full_reg && emit && out_full_reg && out_stall;
    assign out_valid = out_full_reg;
    assign out_data  = out_item_reg;
    assign c = in_item_reg.char_byte;

    always_comb
    begin
        len_next = len_reg; stopped_next = stopped_reg; dollar_next = dollar_reg;
        hdr_next = hdr_reg; hfill_next = hfill_reg; xor_next = xor_reg;
        xstar_next = xstar_reg; star_next = star_reg; rcs_next = rcs_reg;
        hexcnt_next = hexcnt_reg; hexstop_next = hexstop_reg; fidx_next = fidx_reg;
        lcomma_next = lcomma_reg; fval_next = fval_reg; fneg_next = fneg_reg;
        ffirst_next = ffirst_reg; frac_next = frac_reg; phase_next = phase_reg;
        hv = hex_value(c);
        d = c[3:0];
        digit = (c >= "0" && c <= "9");
        cur = 16'd0;
        if (!stopped_reg && len_reg < LenW'(MAX_LINE))
        begin
            if (c == 8'd0)
                stopped_next = 1'b1;
            else if (len_reg == '0)
            begin
                len_next = len_reg + 1'b1;
                dollar_next = (c == "$");
            end
            else
            begin
                len_next = len_reg + 1'b1;
                if (c == "*")
                begin
                    xstar_next = xor_reg; star_next = 1'b1;
                    hexcnt_next = 2'd0; rcs_next = 8'd0; hexstop_next = 1'b0;
                end
                else if (star_reg && hexcnt_reg < 2'd2)
                begin
                    hexcnt_next = hexcnt_reg + 2'd1;
                    if (hv[4]) hexstop_next = 1'b1;
                    else if (!hexstop_reg) rcs_next = {rcs_reg[3:0], hv[3:0]};
                end
                xor_next = xor_reg ^ c;
                if (c == ",")
                begin
                    if (fidx_reg != 4'd15) fidx_next = fidx_reg + 4'd1;
                    lcomma_next = 1'b1; frac_next = 2'd0; phase_next = NUM_LEADING;
                end
                else
                begin
                    lcomma_next = 1'b0;
                    if (fidx_reg == 4'd0 && hfill_reg < 3'd6)
                    begin
                        hdr_next[hfill_reg] = c;
                        hfill_next = hfill_reg + 3'd1;
                    end
                    for (int k = 0; k < KEPT_FIELDS; k++)
                    begin
                        if (fidx_reg == 4'(k))
                        begin
                            cur = fval_reg[k];
                            if (ffirst_reg[k] == 8'd0) ffirst_next[k] = c;
                            if (phase_reg == NUM_LEADING && c == " ")
                                ;
                            else if (phase_reg == NUM_LEADING && (c == "+" || c == "-"))
                            begin
                                fneg_next[k] = (c == "-");
                                phase_next = NUM_INTEGER;
                            end
                            else if (phase_reg == NUM_LEADING || phase_reg == NUM_INTEGER)
                            begin
                                if (digit)
                                begin
                                    fval_next[k] = sat16({4'd0, cur} * 20'd10
                                                         + {16'd0, d} * 20'd100);
                                    phase_next = NUM_INTEGER;
                                end
                                else if (c == ".") phase_next = NUM_FRACTION;
                                else phase_next = NUM_DONE;
                            end
                            else if (phase_reg == NUM_FRACTION)
                            begin
                                if (!digit) phase_next = NUM_DONE;
                                else
                                begin
                                    if (32'(frac_reg) < 32'(FRACTION_DIGITS) && frac_reg < 2'd2)
                                        fval_next[k] = sat16({4'd0, cur} + ((frac_reg == 2'd0) ?
                                            {16'd0, d} * 20'd10 : {16'd0, d}));
                                    if (frac_reg < 2'd3) frac_next = frac_reg + 2'd1;
                                end
                            end
                        end
                    end
                end
            end
        end
        field_count = {1'b0, fidx_next} + (lcomma_next ? 5'd0 : 5'd1);
        checksum_ok = !star_next || hexcnt_next < 2'd2 || xstar_next == rcs_next;
    end

    nwgsp_eval #(.KEPT_FIELDS(KEPT_FIELDS)) u_eval (
        .dollar_first       (dollar_next),
        .long_enough        (len_next >= LenW'(6)),
        .checksum_ok        (checksum_ok),
        .field_count        (field_count),
        .header_fill        (hfill_next),
        .header_letters     (hdr_next),
        .field_values       (fval_next),
        .field_negative     (fneg_next),
        .field_first        (ffirst_next),
        .wind_speed_limit   (wind_limit_reg),
        .ground_speed_limit (ground_limit_reg),
        .seen_in            (seen_reg),
        .result             (eval_result),
        .seen_out           (eval_seen)
    );

    // header letters carry no reset; only written entries are read
    always_ff @(posedge clk)
    begin
        if (step && !in_stall) hdr_reg <= hdr_next;
        if (!in_stall && in_valid) in_item_reg <= in_data;
        if (emit && !in_stall) out_item_reg <= eval_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0; out_full_reg <= 1'b0;
            wind_limit_reg <= WIND_LIMIT_RESET; ground_limit_reg <= GROUND_LIMIT_RESET;
            len_reg <= '0; stopped_reg <= 1'b0; dollar_reg <= 1'b0; hfill_reg <= 3'd0;
            xor_reg <= 8'd0; xstar_reg <= 8'd0; star_reg <= 1'b0; rcs_reg <= 8'd0;
            hexcnt_reg <= 2'd0; hexstop_reg <= 1'b0; fidx_reg <= 4'd0; lcomma_reg <= 1'b0;
            fval_reg <= '0; fneg_reg <= '0; ffirst_reg <= '0; frac_reg <= 2'd0;
            phase_reg <= NUM_LEADING; seen_reg <= 4'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIND_LIMIT) wind_limit_reg <= cfg_wdata;
                if (cfg_index == CFG_GROUND_LIMIT) ground_limit_reg <= cfg_wdata;
            end
            if (!in_stall) in_full_reg <= in_valid;
            if (emit && !in_stall) out_full_reg <= 1'b1;
            else if (!out_stall) out_full_reg <= 1'b0;
            if (step && !in_stall)
            begin
                if (emit)
                begin
                    len_reg <= '0; stopped_reg <= 1'b0; dollar_reg <= 1'b0; hfill_reg <= 3'd0;
                    xor_reg <= 8'd0; xstar_reg <= 8'd0; star_reg <= 1'b0; rcs_reg <= 8'd0;
                    hexcnt_reg <= 2'd0; hexstop_reg <= 1'b0; fidx_reg <= 4'd0;
                    lcomma_reg <= 1'b0; fval_reg <= '0; fneg_reg <= '0; ffirst_reg <= '0;
                    frac_reg <= 2'd0; phase_reg <= NUM_LEADING; seen_reg <= eval_seen;
                end
                else
                begin
                    len_reg <= len_next; stopped_reg <= stopped_next;
                    dollar_reg <= dollar_next; hfill_reg <= hfill_next;
                    xor_reg <= xor_next; xstar_reg <= xstar_next; star_reg <= star_next;
                    rcs_reg <= rcs_next; hexcnt_reg <= hexcnt_next;
                    hexstop_reg <= hexstop_next; fidx_reg <= fidx_next;
                    lcomma_reg <= lcomma_next; fval_reg <= fval_next;
                    fneg_reg <= fneg_next; ffirst_reg <= ffirst_next;
                    frac_reg <= frac_next; phase_reg <= phase_next;
                end
            end
        end
    end

endmodule

[rtl/nwgsp_eval.sv]
// decodes a finished line into one result item
module nwgsp_eval #(
    parameter int KEPT_FIELDS = nwgsp_pkg::KeptFieldsDefault
) (
    input  logic                     dollar_first,
    input  logic                     long_enough,
    input  logic                     checksum_ok,
    input  logic [4:0]               field_count,
    input  logic [2:0]               header_fill,
    input  logic [5:0][7:0]          header_letters,
    input  logic [KEPT_FIELDS-1:0][15:0] field_values,
    input  logic [KEPT_FIELDS-1:0]   field_negative,
    input  logic [KEPT_FIELDS-1:0][7:0] field_first,
    input  logic [15:0]              wind_speed_limit,
    input  logic [15:0]              ground_speed_limit,
    input  logic [3:0]               seen_in,
    output nwgsp_pkg::out_item_t     result,
    output logic [3:0]               seen_out
);
    import nwgsp_pkg::*;

    logic [7:0]  ref_letter;
    logic [7:0]  side_letter;
    logic        base_ok;
    logic        is_mwv, is_vwr, is_vwt, is_rmc, is_vtg, is_hdt, is_hdm;
    logic [15:0] angle_raw;
    logic        angle_pos;
    logic [16:0] angle_sum;
    logic [33:0] angle_prod;
    logic [8:0]  angle_round;
    logic [8:0]  angle_wrap;
    logic [8:0]  angle_side;
    logic [32:0] ms_prod;
    logic [32:0] kmh_prod;
    logic [15:0] ms_knots;
    logic [15:0] kmh_knots;

    function automatic logic hdr(input logic [2:0] fill, input logic [5:0][7:0] h,
                                 input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c);
        return (fill >= 3'd5 && h[2] == a && h[3] == b && h[4] == c) ||
               (fill >= 3'd6 && h[3] == a && h[4] == b && h[5] == c);
    endfunction

    function automatic logic nonneg(input logic neg, input logic [15:0] v);
        return !(neg && v != 16'd0);
    endfunction

    always_comb
    begin
        ref_letter  = to_upper(field_first[2]);
        side_letter = to_upper(field_first[2]);
        base_ok     = dollar_first && long_enough && checksum_ok;
        is_mwv = hdr(header_fill, header_letters, "M", "W", "V");
        is_vwr = hdr(header_fill, header_letters, "V", "W", "R");
        is_vwt = hdr(header_fill, header_letters, "V", "W", "T");
        is_rmc = hdr(header_fill, header_letters, "R", "M", "C");
        is_vtg = hdr(header_fill, header_letters, "V", "T", "G");
        is_hdt = hdr(header_fill, header_letters, "H", "D", "T");
        is_hdm = hdr(header_fill, header_letters, "H", "D", "M");

        angle_raw   = field_values[1];
        angle_pos   = nonneg(field_negative[1], field_values[1]);
        angle_sum   = {1'b0, angle_raw} + 17'd50;
        // divide by 100 as multiply by ceil(2^23 / 100) and shift, exact for sums up to 65585
        angle_prod  = {17'd0, angle_sum} * 34'd83887;
        angle_round = angle_prod[31:23];
        angle_wrap  = (angle_round >= 9'd360) ? angle_round - 9'd360 : angle_round;
        angle_side  = (side_letter == "L" && angle_round != 9'd0) ?
                      9'd360 - angle_round : angle_round;

        ms_prod   = {17'd0, field_values[5]} * {16'd0, MS_TO_KN};
        kmh_prod  = {17'd0, field_values[7]} * {16'd0, KMH_TO_KN};
        ms_knots  = (ms_prod[32:16] > 17'd65535) ? 16'hFFFF : ms_prod[31:16];
        kmh_knots = (kmh_prod[32:16] > 17'd65535) ? 16'hFFFF : kmh_prod[31:16];

        result   = '0;
        seen_out = seen_in;
        if (base_ok)
        begin
            priority if (field_count >= 5'd3 && is_mwv && (ref_letter == "R" || ref_letter == "T")
                         && angle_pos && angle_raw <= FULL_CIRCLE)
            begin
                result.kind           = (ref_letter == "R") ? KIND_APPARENT : KIND_TRUE;
                result.source         = SRC_MWV;
                result.wind_angle_deg = angle_wrap;
                if (field_count >= 5'd4 && nonneg(field_negative[3], field_values[3])
                    && field_values[3] < wind_speed_limit)
                begin
                    result.speed_valid      = 1'b1;
                    result.speed_centiknots = field_values[3];
                end
                seen_out = seen_in | ((ref_letter == "R") ? 4'd1 : 4'd2);
            end
            else if (field_count >= 5'd3 && is_vwr && angle_pos && angle_raw <= HALF_CIRCLE)
            begin
                result.kind           = KIND_APPARENT;
                result.source         = SRC_VWR;
                result.wind_angle_deg = angle_side;
                priority if (field_count >= 5'd5 && nonneg(field_negative[3], field_values[3])
                             && field_values[3] < wind_speed_limit
                             && to_upper(field_first[4]) == "N")
                begin
                    result.speed_valid      = 1'b1;
                    result.speed_centiknots = field_values[3];
                end
                else if (field_count >= 5'd7 && nonneg(field_negative[5], field_values[5])
                         && field_values[5] < wind_speed_limit
                         && to_upper(field_first[6]) == "M")
                begin
                    result.speed_valid      = 1'b1;
                    result.speed_centiknots = ms_knots;
                end
                else if (field_count >= 5'd9 && nonneg(field_negative[7], field_values[7])
                         && field_values[7] < wind_speed_limit
                         && to_upper(field_first[8]) == "K")
                begin
                    result.speed_valid      = 1'b1;
                    result.speed_centiknots = kmh_knots;
                end
                seen_out = seen_in | 4'd4;
            end
            else if (field_count >= 5'd3 && is_vwt && angle_pos && angle_raw <= HALF_CIRCLE)
            begin
                result.kind           = KIND_TRUE;
                result.source         = SRC_VWT;
                result.wind_angle_deg = angle_side;
                if (field_count >= 5'd4 && nonneg(field_negative[3], field_values[3])
                    && field_values[3] < wind_speed_limit)
                begin
                    result.speed_valid      = 1'b1;
                    result.speed_centiknots = field_values[3];
                end
                seen_out = seen_in | 4'd8;
            end
            else if (field_count >= 5'd9 && is_rmc && field_first[2] == "A"
                     && nonneg(field_negative[7], field_values[7])
                     && field_values[7] < ground_speed_limit
                     && nonneg(field_negative[8], field_values[8])
                     && field_values[8] <= FULL_CIRCLE)
            begin
                result.kind             = KIND_GROUND;
                result.source           = SRC_RMC;
                result.speed_valid      = 1'b1;
                result.speed_centiknots = field_values[7];
                result.course_centideg  = field_values[8];
            end
            else if (field_count >= 5'd8 && is_vtg && nonneg(field_negative[5], field_values[5])
                     && field_values[5] < ground_speed_limit
                     && angle_pos && angle_raw <= FULL_CIRCLE)
            begin
                result.kind             = KIND_GROUND;
                result.source           = SRC_VTG;
                result.speed_valid      = 1'b1;
                result.speed_centiknots = field_values[5];
                result.course_centideg  = field_values[1];
            end
            else if (field_count >= 5'd2 && is_hdt && angle_pos && angle_raw <= FULL_CIRCLE)
            begin
                result.kind             = KIND_HEADING;
                result.source           = SRC_HDT;
                result.heading_centideg = field_values[1];
            end
            else if (field_count >= 5'd2 && is_hdm && angle_pos && angle_raw <= FULL_CIRCLE)
            begin
                result.kind             = KIND_HEADING;
                result.source           = SRC_HDM;
                result.heading_centideg = field_values[1];
            end
            else
            begin
                result = '0;
            end
        end
        result.seen_flags = seen_out;
    end

endmodule

[rtl/nwgsp_checker.sv]
module nwgsp_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input nwgsp_pkg::out_item_t out_data
);
    import nwgsp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // a rejection carries no source and no speed
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_REJECT |->
        out_data.source == 3'd0 && !out_data.speed_valid && out_data.speed_centiknots == 16'd0)
        else $error("rejection with payload");

    // no speed without speed_valid
    a_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.speed_valid |-> out_data.speed_centiknots == 16'd0)
        else $error("speed without valid");

    // angle stays in a circle
    a_angle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.wind_angle_deg < 9'd360)
        else $error("angle out of range");

    // input side only stalls while a result waits
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free output");

endmodule

bind nmea_wind_gps_sentence_parser nwgsp_checker u_nwgsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

[verif/tb_nmea_wind_gps_sentence_parser.sv]
module tb_nmea_wind_gps_sentence_parser;
    import nwgsp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    nmea_wind_gps_sentence_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // characters waiting to be sent and decoded sentences waiting to come out
    in_item_t  char_queue[$];
    out_item_t expected_sentences[$];
    int        error_count;
    bit        calm;          // stretch with no idling on either side

    // ------------------------------------------------------------------
    // line decoder mirror: per-line state plus sticky flags and limits
    // ------------------------------------------------------------------
    logic [15:0] wind_limit, ground_limit;
    int          len_so_far;
    bit          halted, dollar_ok, star_hit, hex_bad, comma_last;
    logic [7:0]  hdr[6];
    int          hdr_count;
    logic [7:0]  xsum, xsum_star, sum_rx;
    int          hex_count, field_no, frac_count, phase;
    int          fval[9];
    bit          fneg[9];
    logic [7:0]  first_char[9];
    logic [3:0]  seen_bits;

    function automatic void clear_line_state();
        len_so_far = 0; halted = 0; dollar_ok = 0; hdr_count = 0;
        xsum = 0; xsum_star = 0; star_hit = 0; sum_rx = 0; hex_count = 0; hex_bad = 0;
        field_no = 0; comma_last = 0; frac_count = 0; phase = 0;
        for (int i = 0; i < 6; i++) hdr[i] = 0;
        for (int i = 0; i < 9; i++)
        begin
            fval[i] = 0; fneg[i] = 0; first_char[i] = 0;
        end
    endfunction

    function automatic logic [7:0] caps(logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic int sat(int v);
        return v > 65535 ? 65535 : v;
    endfunction

    // decimal field in hundredths; leading spaces, sign, two fraction digits kept
    function automatic void take_digit(int k, logic [7:0] c);
        bit is_dig;
        int d;
        is_dig = c >= "0" && c <= "9";
        d = int'(c) - 48;
        if (phase == 0 && c == " ") return;
        if (phase == 0 && (c == "+" || c == "-"))
        begin
            fneg[k] = (c == "-"); phase = 1; return;
        end
        if (phase <= 1)
        begin
            if (is_dig)
            begin
                fval[k] = sat(fval[k] * 10 + d * 100); phase = 1;
            end
            else if (c == ".") phase = 2;
            else phase = 3;
        end
        else if (phase == 2)
        begin
            if (!is_dig)
            begin
                phase = 3; return;
            end
            if (frac_count < 2) fval[k] = sat(fval[k] + (frac_count == 0 ? d * 10 : d));
            if (frac_count < 3) frac_count++;
        end
    endfunction

    function automatic int hex_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic void absorb_char(logic [7:0] c);
        int pos, h;
        pos = len_so_far++;
        if (pos == 0)
        begin
            dollar_ok = (c == "$"); return;
        end
        if (c == "*")
        begin
            xsum_star = xsum; star_hit = 1; hex_count = 0; sum_rx = 0; hex_bad = 0;
        end
        else if (star_hit && hex_count < 2)
        begin
            h = hex_of(c);
            hex_count++;
            if (h < 0) hex_bad = 1;
            else if (!hex_bad) sum_rx = {sum_rx[3:0], 4'(h)};
        end
        xsum ^= c;
        if (c == ",")
        begin
            if (field_no < 15) field_no++;
            comma_last = 1; frac_count = 0; phase = 0;
            return;
        end
        comma_last = 0;
        if (field_no == 0 && hdr_count < 6) hdr[hdr_count++] = c;
        if (field_no < 9)
        begin
            if (first_char[field_no] == 0) first_char[field_no] = c;
            take_digit(field_no, c);
        end
    endfunction

    function automatic bit header_is(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        if (hdr_count >= 5 && hdr[2] == a && hdr[3] == b && hdr[4] == c) return 1;
        return hdr_count >= 6 && hdr[3] == a && hdr[4] == b && hdr[5] == c;
    endfunction

    function automatic bit positive(int k);
        return !(fneg[k] && fval[k] != 0);
    endfunction

    function automatic bit within_max(int k, int mx);
        return positive(k) && fval[k] <= mx;
    endfunction

    function automatic bit wind_ok(int k);
        return positive(k) && fval[k] < wind_limit;
    endfunction

    function automatic logic [15:0] knots_of(int v, longint mul);
        longint r;
        r = (longint'(v) * mul) >>> 16;
        return r > 65535 ? 16'hFFFF : 16'(r);
    endfunction

    function automatic logic [8:0] side_deg();
        int a;
        a = (fval[1] + 50) / 100;
        if (caps(first_char[2]) == "L") a = (360 - a) % 360;
        return 9'(a);
    endfunction

    // sentence decode at line end; first matching sentence type wins
    function automatic out_item_t decode_sentence();
        out_item_t r;
        int n;
        bit sum_ok, done;
        logic [7:0] ref_ch;
        r = '0;
        done = 0;
        n = field_no + (comma_last ? 0 : 1);
        sum_ok = !star_hit || hex_count < 2 || xsum_star == sum_rx;
        if (dollar_ok && len_so_far >= 6 && sum_ok)
        begin
            ref_ch = caps(first_char[2]);
            if (n >= 3 && header_is("M", "W", "V") && (ref_ch == "R" || ref_ch == "T")
                && within_max(1, 36000))
            begin
                r.kind = ref_ch == "R" ? KIND_APPARENT : KIND_TRUE;
                r.source = SRC_MWV;
                r.wind_angle_deg = 9'(((fval[1] + 50) / 100) % 360);
                if (n >= 4 && wind_ok(3))
                begin
                    r.speed_valid = 1; r.speed_centiknots = 16'(fval[3]);
                end
                seen_bits |= ref_ch == "R" ? 4'd1 : 4'd2;
                done = 1;
            end
            if (!done && n >= 3 && header_is("V", "W", "R") && within_max(1, 18000))
            begin
                r.kind = KIND_APPARENT; r.source = SRC_VWR; r.wind_angle_deg = side_deg();
                if (n >= 5 && wind_ok(3) && caps(first_char[4]) == "N")
                begin
                    r.speed_valid = 1; r.speed_centiknots = 16'(fval[3]);
                end
                else if (n >= 7 && wind_ok(5) && caps(first_char[6]) == "M")
                begin
                    r.speed_valid = 1; r.speed_centiknots = knots_of(fval[5], 127392);
                end
                else if (n >= 9 && wind_ok(7) && caps(first_char[8]) == "K")
                begin
                    r.speed_valid = 1; r.speed_centiknots = knots_of(fval[7], 35387);
                end
                seen_bits |= 4'd4;
                done = 1;
            end
            if (!done && n >= 3 && header_is("V", "W", "T") && within_max(1, 18000))
            begin
                r.kind = KIND_TRUE; r.source = SRC_VWT; r.wind_angle_deg = side_deg();
                if (n >= 4 && wind_ok(3))
                begin
                    r.speed_valid = 1; r.speed_centiknots = 16'(fval[3]);
                end
                seen_bits |= 4'd8;
                done = 1;
            end
            if (!done && n >= 9 && header_is("R", "M", "C") && first_char[2] == "A"
                && positive(7) && fval[7] < ground_limit && within_max(8, 36000))
            begin
                r.kind = KIND_GROUND; r.source = SRC_RMC; r.speed_valid = 1;
                r.speed_centiknots = 16'(fval[7]); r.course_centideg = 16'(fval[8]);
                done = 1;
            end
            if (!done && n >= 8 && header_is("V", "T", "G") && positive(5)
                && fval[5] < ground_limit && within_max(1, 36000))
            begin
                r.kind = KIND_GROUND; r.source = SRC_VTG; r.speed_valid = 1;
                r.speed_centiknots = 16'(fval[5]); r.course_centideg = 16'(fval[1]);
                done = 1;
            end
            if (!done && n >= 2 && header_is("H", "D", "T") && within_max(1, 36000))
            begin
                r.kind = KIND_HEADING; r.source = SRC_HDT; r.heading_centideg = 16'(fval[1]);
                done = 1;
            end
            if (!done && n >= 2 && header_is("H", "D", "M") && within_max(1, 36000))
            begin
                r.kind = KIND_HEADING; r.source = SRC_HDM; r.heading_centideg = 16'(fval[1]);
            end
        end
        r.seen_flags = seen_bits;
        return r;
    endfunction

    // one accepted character; a flagged one closes the line
    function automatic void take_char(in_item_t it);
        if (!halted && len_so_far < 255)
        begin
            if (it.char_byte == 0) halted = 1;
            else absorb_char(it.char_byte);
        end
        if (it.end_of_line)
        begin
            expected_sentences.push_back(decode_sentence());
            clear_line_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // idle draws for both sides, with runs of zero
    // ------------------------------------------------------------------
    function automatic int draw_idle();
        if ($urandom_range(0, 49) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // driver: one char request at a time from char_queue
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        bit accepted, next_valid;
        if (!rst_n)
        begin
            in_valid <= 0;
            in_data  <= '0;
            send_gap = 0;
        end
        else
        begin
            accepted = in_valid && !in_stall;
            next_valid = in_valid && !accepted;
            if (accepted) take_char(in_data);
            if (!next_valid)
            begin
                if (send_gap > 0) send_gap--;
                else if (char_queue.size() > 0)
                begin
                    in_data <= char_queue.pop_front();
                    next_valid = 1;
                    send_gap = draw_idle();
                end
            end
            in_valid <= next_valid;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // monitor: random stall per result, check against the oldest expectation
    int hold_cycles;
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 0;
            hold_cycles = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_sentences.size() == 0)
                    report_mismatch("unexpected result kind", out_data.kind, -1);
                else
                begin
                    want = expected_sentences.pop_front();
                    if (out_data.kind != want.kind)
                        report_mismatch("kind", out_data.kind, want.kind);
                    if (out_data.source != want.source)
                        report_mismatch("source", out_data.source, want.source);
                    if (out_data.wind_angle_deg != want.wind_angle_deg)
                        report_mismatch("wind_angle_deg", out_data.wind_angle_deg,
                                        want.wind_angle_deg);
                    if (out_data.speed_valid != want.speed_valid)
                        report_mismatch("speed_valid", out_data.speed_valid, want.speed_valid);
                    if (out_data.speed_centiknots != want.speed_centiknots)
                        report_mismatch("speed_centiknots", out_data.speed_centiknots,
                                        want.speed_centiknots);
                    if (out_data.course_centideg != want.course_centideg)
                        report_mismatch("course_centideg", out_data.course_centideg,
                                        want.course_centideg);
                    if (out_data.heading_centideg != want.heading_centideg)
                        report_mismatch("heading_centideg", out_data.heading_centideg,
                                        want.heading_centideg);
                    if (out_data.seen_flags != want.seen_flags)
                        report_mismatch("seen_flags", out_data.seen_flags, want.seen_flags);
                end
                hold_cycles = draw_idle();
            end
            else if (hold_cycles > 0) hold_cycles--;
            out_stall <= hold_cycles != 0;
        end
    end

    // ------------------------------------------------------------------
    // sentence building
    // ------------------------------------------------------------------
    task automatic queue_line(string s, bit with_nul);
        int nul_at;
        nul_at = with_nul ? $urandom_range(0, s.len() - 1) : -1;
        for (int i = 0; i < s.len(); i++)
        begin
            if (i == nul_at) char_queue.push_back('{8'h00, 1'b0});
            char_queue.push_back('{s[i], i == s.len() - 1});
        end
    endtask

    // body without '$'; checksum appended correct, missing, wrong or odd
    function automatic string framed(string body, int style);
        logic [7:0] x;
        x = 0;
        for (int i = 0; i < body.len(); i++) x ^= body[i];
        case (style)
            0: return {"$", body, $sformatf("*%02X", x)};
            1: return {"$", body, $sformatf("*%02x", x)};
            2: return {"$", body};
            3: return {"$", body, $sformatf("*%02X", x ^ 8'(1 << $urandom_range(0, 7)))};
            4: return {"$", body, $sformatf("*%1X", x[7:4])};
            default: return {"$", body, "*G1"};
        endcase
    endfunction

    function automatic string digits(int v, int count);
        string s;
        s = $sformatf("%0d", v);
        while (s.len() < count) s = {"0", s};
        return s;
    endfunction

    // random decimal text with integer part up to top, or an empty, oversized or malformed field
    function automatic string rand_num(int top);
        string s;
        int nd;
        case ($urandom_range(0, 19))
            0: return "";
            1: return $sformatf("%0d", $urandom_range(600, 99999));
            2: return "x1";
            default: ;
        endcase
        s = "";
        if ($urandom_range(0, 9) == 0) s = " ";
        if ($urandom_range(0, 9) == 0) s = {s, $urandom_range(0, 1) ? "-" : "+"};
        s = {s, $sformatf("%0d", $urandom_range(0, top))};
        nd = $urandom_range(0, 3);
        if (nd > 0) s = {s, ".", digits($urandom_range(0, 999), 3).substr(0, nd - 1)};
        return s;
    endfunction

    function automatic string pick(string a, string b, string c);
        int r;
        r = $urandom_range(0, 9);
        return r < 7 ? a : (r < 9 ? b : c);
    endfunction

    function automatic string talker();
        case ($urandom_range(0, 5))
            0: return "GP";
            1: return "PQR";
            2: return "W";
            default: return "II";
        endcase
    endfunction

    function automatic string rand_sentence();
        string t, b;
        t = talker();
        case ($urandom_range(0, 6))
            0: b = {t, "MWV,", rand_num(370), ",", pick("R", "t", "X"), ",",
                    rand_num(250), ",N,A"};
            1: b = {t, "VWR,", rand_num(190), ",", pick("L", "r", "x"), ",",
                    rand_num(250), ",", pick("N", "m", "K"), ",", rand_num(150), ",",
                    pick("M", "k", "N"), ",", rand_num(500), ",", pick("K", "n", "m")};
            2: b = {t, "VWT,", rand_num(190), ",", pick("R", "l", "Z"), ",",
                    rand_num(250), ",N"};
            3: b = {t, "RMC,123519,", pick("A", "V", "a"), ",4807.038,N,01131.000,E,",
                    rand_num(120), ",", rand_num(370), ",230394"};
            4: b = {t, "VTG,", rand_num(370), ",T,,M,", rand_num(120), ",N,",
                    rand_num(200), ",K"};
            5: b = {t, "HDT,", rand_num(370), pick(",T", "", ",")};
            default: b = {t, "HDM,", rand_num(370), pick(",M", "", ",")};
        endcase
        return framed(b, $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 5));
    endfunction

    // unstructured bytes, every value possible, ended by a flagged byte
    task automatic queue_noise(int count);
        for (int i = 0; i < count; i++)
            char_queue.push_back('{8'($urandom_range(0, 255)), i == count - 1});
    endtask

    task automatic queue_random(int target_items);
        int start;
        start = char_queue.size();
        while (char_queue.size() - start < target_items)
        begin
            if ($urandom_range(0, 9) < 8) queue_line(rand_sentence(), $urandom_range(0, 29) == 0);
            else queue_noise($urandom_range(1, 30));
        end
    endtask

    // hold until the block has drained, then allow its output register to settle
    task automatic wait_drained();
        while (char_queue.size() > 0 || in_valid || expected_sentences.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_limits(logic [15:0] wind, logic [15:0] ground);
        @(posedge clk);
        cfg_we <= 1; cfg_index <= CFG_WIND_LIMIT; cfg_wdata <= wind;
        @(posedge clk);
        cfg_index <= CFG_GROUND_LIMIT; cfg_wdata <= ground;
        @(posedge clk);
        cfg_we <= 0;
        wind_limit = wind;
        ground_limit = ground;
    endtask

    initial
    begin
        string long_line;
        clk = 0; rst_n = 0; calm = 0; error_count = 0;
        cfg_we = 0; cfg_index = CFG_WIND_LIMIT; cfg_wdata = 0;
        clear_line_state();
        seen_bits = 0;
        wind_limit = WIND_LIMIT_RESET;
        ground_limit = GROUND_LIMIT_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1;

        // directed: each sentence type, both wind sides and units, odd checksums
        queue_line(framed("WIMWV,359.5,R,12.3,N,A", 0), 0);
        queue_line(framed("WIMWV,-0,T,199.99,N,A", 0), 0);
        queue_line(framed("IIVWR,180.0,L,,N,5.5,M,,K", 0), 0);
        queue_line(framed("IIVWR,90.49,l,,N,,M,655.35,k", 0), 0);
        queue_line(framed("IIVWT,0.5,R,  +7.129,N", 1), 0);
        queue_line(framed("GPRMC,1,A,1,N,1,E,99.99,360.00,1", 0), 0);
        queue_line(framed("GPVTG,360,T,,M,0.01,N,0,K", 0), 0);
        queue_line(framed("PXXHDT,274.5", 0), 0);
        queue_line(framed("HCHDM,360.01,M", 0), 0);
        queue_line(framed("wimwv,10,R,1", 0), 0);
        queue_line(framed("WIMWV,10,R,1", 3), 0);
        queue_line(framed("WIMWV,10,R,1", 5), 0);
        queue_line("$IIHDT,12.3,T,", 1);
        queue_line("$HDT,", 0);
        queue_line("WIMWV,10,R,1,N,A", 0);
        long_line = "$IIHDT,1.5";
        while (long_line.len() < 300) long_line = {long_line, ",9"};
        queue_line(long_line, 0);
        queue_random(180);
        // sender pauses here until every expected result has come
        wait_drained();

        write_limits(16'd0, 16'hFFFF);
        queue_random(90);
        wait_drained();
        write_limits(16'hFFFF, 16'd0);
        queue_random(90);
        wait_drained();
        write_limits(16'd5000, 16'd3000);
        queue_random(90);
        wait_drained();

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[nmea_wind_gps_sentence_parser.f]
rtl/nwgsp_pkg.sv
rtl/nwgsp_eval.sv
rtl/nmea_wind_gps_sentence_parser.sv
rtl/nwgsp_checker.sv
verif/tb_nmea_wind_gps_sentence_parser.sv
